[rtl/mhts_pkg.sv]
// Shared types and constants for the matrix trace-of-square accumulator.
// No dependencies; every other file in rtl/ imports this package.

package mhts_pkg;

	localparam int WORD_W       = 32;
	localparam int CFG_W        = 7;
	localparam int SIZE_RESET   = 64;
	localparam int MAX_SIZE_DEF = 64;
	localparam int QUEUE_DEPTH  = 4;

	// What the back end does with a word
	typedef enum logic [1:0] {
		OP_STORE  = 2'd0,
		OP_SQUARE = 2'd1,
		OP_MIRROR = 2'd2
	} op_t;

	typedef struct packed {
		op_t  op;
		logic last;
	} ctl_t;

endpackage

[rtl/matrix_hadamard_transpose_sum_top.sv]
// Top level of the matrix trace-of-square accumulator.
// Depends on mhts_pkg, mhts_front, mhts_fifo and mhts_back.

// Feed the elements of a square signed matrix one word per cycle in row-major
// order; after the last element one word on the output carries the sum over
// all i,j of A[i][j]*A[j][i] (equal to trace(A*A)), wrapped to 32 bits. The
// size comes from cfg_wdata (written with cfg_we while the block is idle);
// zero counts as 1 and values above MAX_SIZE saturate. A write also restarts
// the matrix. The block takes one word every cycle while not stalled; the
// single store port (one write or one mirror read per word) and the one
// multiplier per word set that figure. With the queue empty, out_valid rises
// once the last element clears the read and multiply stages. Elements above
// the diagonal go into a MAX_SIZE*MAX_SIZE word store that needs no clearing
// pass: every mirror read hits an entry written earlier in the same matrix.
// A four-word queue separates the input counters from the store and multiply
// pipe. The output register parts the result from the pipe, so the input
// keeps flowing while a finished sum waits on out_stall; only a second
// finished sum reaching the accumulator before the first is taken holds the
// pipe, and the input then stalls once the queue has filled.

module matrix_hadamard_transpose_sum_top #(
	parameter int MAX_SIZE = mhts_pkg::MAX_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mhts_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [mhts_pkg::WORD_W-1:0] element,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [mhts_pkg::WORD_W-1:0] grand_sum
);
	import mhts_pkg::*;

	localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int QW = $bits(ctl_t) + WORD_W + AW;

	logic              push, pop, q_full, q_valid;
	ctl_t              push_ctl, q_ctl;
	logic [WORD_W-1:0] push_elem, q_elem;
	logic [AW-1:0]     push_addr, q_addr;
	logic [QW-1:0]     q_wdata, q_rdata;

	// Count rows and columns, classify each word
	mhts_front #(
		.MAX_SIZE(MAX_SIZE),
		.AW      (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.element  (element),
		.q_full   (q_full),
		.push     (push),
		.push_ctl (push_ctl),
		.push_elem(push_elem),
		.push_addr(push_addr)
	);

	assign q_wdata = {push_ctl, push_elem, push_addr};
	assign {q_ctl, q_elem, q_addr} = q_rdata;

	// Decouple the counters from the store and multiply pipe
	mhts_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(q_wdata),
		.full     (q_full),
		.not_empty(q_valid),
		.pop      (pop),
		.pop_data (q_rdata)
	);

	// Store, multiply, accumulate, hold the result
	mhts_back #(
		.MAX_SIZE(MAX_SIZE),
		.AW      (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_we),
		.q_valid  (q_valid),
		.pop      (pop),
		.q_ctl    (q_ctl),
		.q_elem   (q_elem),
		.q_addr   (q_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.grand_sum(grand_sum)
	);

endmodule

[rtl/mhts_front.sv]
// Front end: size register, row/column tracking, word classification and store address.
// Depends on mhts_pkg.

module mhts_front #(
	parameter int MAX_SIZE = mhts_pkg::MAX_SIZE_DEF,
	parameter int AW       = $clog2(MAX_SIZE * MAX_SIZE)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mhts_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [mhts_pkg::WORD_W-1:0] element,
	input  logic                              q_full,
	output logic                              push,
	output mhts_pkg::ctl_t                    push_ctl,
	output logic [mhts_pkg::WORD_W-1:0]       push_elem,
	output logic [AW-1:0]                     push_addr
);
	import mhts_pkg::*;

	localparam int IDX_W = $clog2(MAX_SIZE);
	localparam int SZ_W  = $clog2(MAX_SIZE + 1);
	localparam int CMP_W = (SZ_W > CFG_W) ? SZ_W : CFG_W;
	localparam int RST_SIZE = (MAX_SIZE < SIZE_RESET) ? MAX_SIZE : SIZE_RESET;

	logic [IDX_W-1:0] row_q, col_q;
	logic [SZ_W-1:0]  size_q, size_d;
	logic [CMP_W-1:0] cfg_ext;
	logic             col_last, row_last;
	logic [IDX_W-1:0] addr_hi, addr_lo;
	op_t              op;

	// Clamp the written size into 1..MAX_SIZE
	always_comb begin
		cfg_ext = CMP_W'(cfg_wdata);
		if (cfg_ext == '0) begin
			size_d = SZ_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_SIZE)) begin
			size_d = SZ_W'(MAX_SIZE);
		end else begin
			size_d = SZ_W'(cfg_ext);
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign col_last = (SZ_W'(col_q) + SZ_W'(1)) >= size_q;
	assign row_last = (SZ_W'(row_q) + SZ_W'(1)) >= size_q;

	always_comb begin
		priority if (row_q < col_q) begin
			op = OP_STORE;
		end else if (row_q == col_q) begin
			op = OP_SQUARE;
		end else begin
			op = OP_MIRROR;
		end
	end

	// Mirror reads use the transposed position
	assign addr_hi = (op == OP_MIRROR) ? col_q : row_q;
	assign addr_lo = (op == OP_MIRROR) ? row_q : col_q;

	assign push_addr     = AW'(AW'(addr_hi) * AW'(MAX_SIZE)) + AW'(addr_lo);
	assign push_elem     = $unsigned(element);
	assign push_ctl.op   = op;
	assign push_ctl.last = col_last && row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			size_q <= SZ_W'(RST_SIZE);
		end else if (cfg_we) begin
			row_q  <= '0;
			col_q  <= '0;
			size_q <= size_d;
		end else if (push) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

endmodule

[rtl/mhts_fifo.sv]
// Short word queue between front and back ends.
// Depends on mhts_pkg for the default depth.

module mhts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mhts_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             not_empty,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);
	import mhts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

[rtl/mhts_back.sv]
// Back end: upper-triangle store, multiplier stage, accumulator and result register.
// Depends on mhts_pkg.

module mhts_back #(
	parameter int MAX_SIZE = mhts_pkg::MAX_SIZE_DEF,
	parameter int AW       = $clog2(MAX_SIZE * MAX_SIZE)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               q_valid,
	output logic                               pop,
	input  mhts_pkg::ctl_t                     q_ctl,
	input  logic [mhts_pkg::WORD_W-1:0]        q_elem,
	input  logic [AW-1:0]                      q_addr,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [mhts_pkg::WORD_W-1:0] grand_sum
);
	import mhts_pkg::*;

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;

	logic [WORD_W-1:0] store_mem [DEPTH];

	logic              adv;
	logic              valid_s1, valid_s2;
	ctl_t              ctl_s1, ctl_s2;
	logic [WORD_W-1:0] elem_s1, rd_s1;
	logic [WORD_W-1:0] operand, prod_s2, term, sum;
	logic [WORD_W-1:0] acc_q, sum_q;
	logic              valid_q;

	// Hold the pipe only when a second sum would overwrite one still waiting
	assign adv = !(valid_q && out_stall && valid_s2 && ctl_s2.last);
	assign pop = adv && q_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_ctl.op == OP_STORE) begin
				store_mem[q_addr] <= q_elem;
			end
			rd_s1 <= store_mem[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s1  <= q_ctl;
			elem_s1 <= q_elem;
		end
		if (adv && valid_s1) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= elem_s1 * operand;
		end
	end

	assign operand = (ctl_s1.op == OP_MIRROR) ? rd_s1 : elem_s1;

	always_comb begin
		unique case (ctl_s2.op)
			OP_SQUARE: term = prod_s2;
			OP_MIRROR: term = {prod_s2[WORD_W-2:0], 1'b0};
			default:   term = '0;
		endcase
	end

	assign sum = acc_q + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (adv) begin
				valid_s1 <= q_valid;
				valid_s2 <= valid_s1;
			end
			if (adv && valid_s2 && ctl_s2.last) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
			if (clear) begin
				acc_q <= '0;
			end else if (adv && valid_s2) begin
				acc_q <= ctl_s2.last ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && ctl_s2.last) begin
			sum_q <= sum;
		end
	end

	assign out_valid = valid_q;
	assign grand_sum = $signed(sum_q);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for matrix_hadamard_transpose_sum_top (trace of A squared).
// Needs only mhts_pkg and the RTL under rtl/. It streams matrices through the block
// and checks every returned sum against a built-in running-trace predictor.
`timescale 1ns / 1ps

module tb_top;

	import mhts_pkg::*;

	localparam int SIDE_MAX      = MAX_SIZE_DEF;
	localparam int SETTLE_CYCLES = 12;       // time for the pipe and the queue to empty, with margin
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int WARMUP_WORDS  = 100;      // partial large matrix: no sum may appear
	localparam int RANDOM_WORDS  = 780;
	localparam int TAIL_WORDS    = 650;      // past this point nobody idles
	localparam int REPORT_MAX    = 10;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_W-1:0]         cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [WORD_W-1:0] element;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [WORD_W-1:0] grand_sum;

	// Directed rows: an optional size write ahead of the word, and the sum where it is obvious
	typedef struct packed {
		bit               set_size;
		logic [CFG_W-1:0] size;
		logic [31:0]      elem;
		bit               known;
		logic [31:0]      sum;
	} probe_t;

	probe_t probe_rows [0:23] = '{
		// 1x1 matrices: each word is its own square
		'{1'b1, 7'd1, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{1'b0, 7'd0, 32'h0000_0001, 1'b1, 32'h0000_0001},
		'{1'b0, 7'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
		'{1'b0, 7'd0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0001},
		'{1'b0, 7'd0, 32'h8000_0000, 1'b1, 32'h0000_0000},
		'{1'b0, 7'd0, 32'h0000_FFFF, 1'b1, 32'hFFFE_0001},
		// size code zero behaves as 1
		'{1'b1, 7'd0, 32'h0000_0003, 1'b1, 32'h0000_0009},
		// 2x2: a*a + d*d + 2*b*c
		'{1'b1, 7'd2, 32'h0000_0001, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h0000_0002, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h0000_0003, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h0000_0004, 1'b1, 32'd29},
		// 2x2 at the extremes: the mirror product wraps to zero
		'{1'b0, 7'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h8000_0000, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h8000_0000, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h7FFF_FFFF, 1'b1, 32'd2},
		// 3x3, left to the predictor
		'{1'b1, 7'd3, 32'd1, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'd2, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'd3, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'hFFFF_FFFC, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'd5, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'd6, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h8000_0001, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'd8, 1'b0, 32'h0},
		'{1'b0, 7'd0, 32'h7FFF_FFFE, 1'b0, 32'h0}
	};

	// Predictor state: mirror store, position in the matrix, running sum, side length
	logic [31:0] mirror_store [0:SIDE_MAX*SIDE_MAX-1];
	int          row_idx;
	int          col_idx;
	logic [31:0] trace_acc;
	int          side_len;

	logic [31:0] sum_queue [$];  // sums still owed by the block, oldest first
	bit          allow_gaps;
	int          stall_left;
	int          err_count;
	int          bad_sums;
	int          sums_seen;
	int          words_sent;
	int          random_words;
	int          sizes_set;
	int          cycle_count;

	matrix_hadamard_transpose_sum_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.element   (element),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.grand_sum (grand_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror a size write: clamp the code, restart the matrix
	task automatic apply_size(input logic [CFG_W-1:0] code);
		side_len  = (code == 0) ? 1 : ((code > SIDE_MAX) ? SIDE_MAX : int'(code));
		row_idx   = 0;
		col_idx   = 0;
		trace_acc = '0;
	endtask

	// Advance the predictor by one element; flag the sum when the matrix closes
	task automatic fold_element(input logic [31:0] e, output bit done, output logic [31:0] sum);
		logic [31:0] prod;
		done = 1'b0;
		sum  = '0;
		if (row_idx < col_idx) begin
			mirror_store[row_idx*SIDE_MAX + col_idx] = e;
		end else if (row_idx == col_idx) begin
			trace_acc += e * e;
		end else begin
			prod = e * mirror_store[col_idx*SIDE_MAX + row_idx];
			trace_acc += prod << 1;
		end
		if (col_idx + 1 >= side_len) begin
			col_idx = 0;
			if (row_idx + 1 >= side_len) begin
				done      = 1'b1;
				sum       = trace_acc;
				row_idx   = 0;
				trace_acc = '0;
			end else begin
				row_idx++;
			end
		end else begin
			col_idx++;
		end
	endtask

	// Present one word, hold it until it is taken, then fold it into the prediction.
	// A typed sum, where given, replaces the predicted one as the expectation.
	task automatic push_word(input logic [31:0] e, input bit typed, input logic [31:0] typed_sum);
		bit          done;
		logic [31:0] sum;
		if (allow_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		element  <= e;
		do @(posedge clk); while (in_stall);
		words_sent++;
		fold_element(e, done, sum);
		if (done)
			sum_queue.push_back(typed ? typed_sum : sum);
	endtask

	// Drop valid, drain all owed sums, let the pipe settle, then write the size
	task automatic write_size(input logic [CFG_W-1:0] code);
		in_valid <= 1'b0;
		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_size(code);
		sizes_set++;
	endtask

	// Mostly full-range values, with extremes and small signed values mixed in
	function automatic logic [31:0] rand_element();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
				0:       return 32'h0000_0000;
				1:       return 32'h0000_0001;
				2:       return 32'hFFFF_FFFF;
				3:       return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		if (pick <= 3)
			return 32'($signed($urandom_range(0, 200)) - 100);
		return $urandom;
	endfunction

	// Receiver: stall in random bursts while idling is allowed
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check every accepted sum against the oldest one owed
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			sums_seen++;
			if (sum_queue.size() == 0) begin
				err_count++;
				bad_sums++;
				if (bad_sums <= REPORT_MAX)
					$display("[%0t] unexpected sum %h with nothing owed", $realtime, grand_sum);
			end else begin
				want = sum_queue.pop_front();
				if (grand_sum !== want) begin
					err_count++;
					bad_sums++;
					if (bad_sums <= REPORT_MAX)
						$display("[%0t] grand_sum mismatch: expected %h, got %h",
							$realtime, want, grand_sum);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sums still owed", cycle_count,
				sum_queue.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int code;
		int side;
		int count;
		bit partial;

		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		element    <= '0;
		allow_gaps = 1'b1;
		stall_left = 0;
		err_count  = 0;
		bad_sums   = 0;
		sums_seen  = 0;
		words_sent = 0;
		random_words = 0;
		sizes_set  = 0;
		cycle_count = 0;
		apply_size(7'(SIZE_RESET));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size: the start of a 64x64 matrix, abandoned by the next size write
		for (int k = 0; k < WARMUP_WORDS; k++)
			push_word(rand_element(), 1'b0, '0);

		// Directed rows
		foreach (probe_rows[k]) begin
			if (probe_rows[k].set_size)
				write_size(probe_rows[k].size);
			push_word(probe_rows[k].elem, probe_rows[k].known, probe_rows[k].sum);
		end

		// Largest code saturates to the maximum side: no sum within the first rows
		write_size(7'h7F);
		for (int k = 0; k < WARMUP_WORDS; k++)
			push_word(rand_element(), 1'b0, '0);

		// Random phases: mostly whole small matrices, sometimes a trailing partial one
		// that the next size write abandons, now and then an oversize code fed briefly
		while (random_words < RANDOM_WORDS) begin
			code = $urandom_range(0, 99);
			partial = 1'b0;
			if (code < 5) begin
				code = 0;
			end else if (code < 10) begin
				code = 1;
			end else if (code < 80) begin
				code = $urandom_range(2, 8);
			end else if (code < 95) begin
				code = $urandom_range(9, 16);
			end else begin
				code = $urandom_range(SIDE_MAX + 1, 127);
				partial = 1'b1;
			end
			if (random_words < TAIL_WORDS)
				allow_gaps = ($urandom_range(0, 3) != 0);
			write_size(7'(code));
			side = (code == 0) ? 1 : code;
			if (partial) begin
				count = $urandom_range(1, 60);
			end else begin
				count = $urandom_range(1, 4) * side * side;
				if (side > 1 && $urandom_range(0, 3) == 0)
					count += $urandom_range(1, side*side - 1);
			end
			if (count > RANDOM_WORDS - random_words)
				count = RANDOM_WORDS - random_words;
			for (int k = 0; k < count; k++) begin
				if (random_words >= TAIL_WORDS)
					allow_gaps = 1'b0;
				push_word(rand_element(), 1'b0, '0);
				random_words++;
			end
		end

		// Drain: wait for every owed sum, then keep watching for any stray one
		in_valid <= 1'b0;
		while (sum_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d elements over %0d size writes, %0d of them random",
			words_sent, sizes_set, random_words);
		$display("checked %0d trace sums, %0d mismatches", sums_seen, bad_sums);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
